>>> hdl/brcd_pkg.sv
// Shared types, constants and counter update function for the binary rANS decoder.
`default_nettype none

package brcd_pkg;

	localparam int LANES       = 16;
	localparam int LANE_W      = 4;
	localparam int PROB_BITS   = 15;
	localparam int STATE_W     = 32;
	localparam int NODE_W      = 8;
	localparam int NODES       = 256;
	localparam int BANK_DEPTH  = NODES / 2;
	localparam int BANK_AW     = NODE_W - 1;
	localparam int CNT_W       = 8;
	localparam int NIB_W       = 4;
	localparam int POS_W       = 3;
	localparam int LOW_BOUND   = 1 << (PROB_BITS + 8);
	localparam int LOW_BOUND2  = 1 << PROB_BITS;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_DECODE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [LANE_W-1:0]  lane;
		logic [STATE_W-1:0] init_state;
		logic [7:0]         peek_first;
		logic [7:0]         peek_second;
	} in_item_t;

	typedef struct packed {
		logic              bit_res;
		logic [1:0]        consumed;
		logic              byte_done;
		logic [7:0]        out_byte;
		logic [LANE_W-1:0] next_lane;
	} out_item_t;

	// Bump the count for the decoded bit; halve both with round-up on overflow.
	function automatic logic [CNT_W-1:0] count_next(input logic [CNT_W-1:0] st,
			input logic b);
		logic [NIB_W:0] n0;
		logic [NIB_W:0] n1;
		n0 = {1'b0, st[NIB_W-1:0]} + {{NIB_W{1'b0}}, ~b};
		n1 = {1'b0, st[CNT_W-1:NIB_W]} + {{NIB_W{1'b0}}, b};
		if (n0[NIB_W] || n1[NIB_W]) begin
			n0 = (n0 + 1'b1) >> 1;
			n1 = (n1 + 1'b1) >> 1;
		end
		return {n1[NIB_W-1:0], n0[NIB_W-1:0]};
	endfunction

endpackage

`default_nettype wire

>>> hdl/brcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module brcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/brcd_prob_rom.sv
// Constant table of zero probabilities indexed by counter state.
`default_nettype none

module brcd_prob_rom (
	input  wire logic [brcd_pkg::CNT_W-1:0]     st,
	output logic      [brcd_pkg::PROB_BITS-1:0] p
);

	logic [brcd_pkg::PROB_BITS-1:0] prob_tab [brcd_pkg::NODES];

	for (genvar i = 0; i < brcd_pkg::NODES; i++) begin : g_ent
		localparam int N0   = i % 16;
		localparam int N1   = i / 16;
		localparam int PROB = ((2 * N0 + 1) << brcd_pkg::PROB_BITS) / (2 * (N0 + N1) + 2);
		assign prob_tab[i] = PROB[brcd_pkg::PROB_BITS-1:0];
	end

	assign p = prob_tab[st];

endmodule

`default_nettype wire

>>> hdl/brcd_rans_step.sv
// One binary rANS decode step: refill from peeked bytes, split, decide the bit, update.
`default_nettype none

module brcd_rans_step (
	input  wire logic [brcd_pkg::STATE_W-1:0]   x,
	input  wire logic [brcd_pkg::PROB_BITS-1:0] p,
	input  wire logic [7:0]                     peek_first,
	input  wire logic [7:0]                     peek_second,
	output logic                                bit_res,
	output logic      [1:0]                     consumed,
	output logic      [brcd_pkg::STATE_W-1:0]   x_next
);

	localparam int SW = brcd_pkg::STATE_W;
	localparam int PB = brcd_pkg::PROB_BITS;

	logic [SW-1:0]    xr;
	logic [PB-1:0]    s;
	logic [SW-PB-1:0] q;
	logic [SW-1:0]    a;
	logic [SW-1:0]    p_ext;
	logic [SW-1:0]    s_ext;

	always_comb begin
		if (x < SW'(brcd_pkg::LOW_BOUND2)) begin
			xr       = {x[SW-17:0], peek_first, peek_second};
			consumed = 2'd2;
		end else if (x < SW'(brcd_pkg::LOW_BOUND)) begin
			xr       = {x[SW-9:0], peek_first};
			consumed = 2'd1;
		end else begin
			xr       = x;
			consumed = 2'd0;
		end
	end

	assign s       = xr[PB-1:0];
	assign q       = xr[SW-1:PB];
	assign p_ext   = SW'(p);
	assign a       = p_ext * SW'(q);
	assign s_ext   = SW'(s);
	assign bit_res = (s >= p);
	assign x_next  = bit_res ? (xr - p_ext - a) : (a + s_ext);

endmodule

`default_nettype wire

>>> hdl/binary_rans_context_decoder_top.sv
// Binary rANS context decoder: input register, decode stage, result register.
// An accepted transaction is decoded from the input register into the result register.
// Throughput: one transaction per cycle unless the result register stalls; the counter
// pair for both next contexts is fetched from two banked RAMs while the bit decodes.
// Reset clears control state and marks every counter as zero at once (no clearing pass).
// Lane states are undefined until loaded.
`default_nettype none

module binary_rans_context_decoder_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire brcd_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output brcd_pkg::out_item_t      result
);

	localparam int SW = brcd_pkg::STATE_W;
	localparam int NW = brcd_pkg::NODE_W;
	localparam int PW = brcd_pkg::POS_W;
	localparam int CW = brcd_pkg::CNT_W;

	brcd_pkg::in_item_t  item_s1;
	logic                s1_valid_q;
	logic                s1_adv;

	logic [SW-1:0]       lane_q [brcd_pkg::LANES];
	logic [NW-1:0]       ctx_q;
	logic [NW-1:0]       ctx_d;
	logic [PW-1:0]       pos_q;
	logic [PW-1:0]       pos_d;
	logic                grp_q;
	logic                grp_d;
	logic [brcd_pkg::NODES-1:0] cnt_valid_q;

	logic [brcd_pkg::LANE_W-1:0] cur_lane;
	logic [CW-1:0]       even_rd;
	logic [CW-1:0]       odd_rd;
	logic [CW-1:0]       cnt_raw;
	logic [CW-1:0]       cnt_st;
	logic [CW-1:0]       cnt_new;
	logic [brcd_pkg::PROB_BITS-1:0] p;
	logic                dec_bit;
	logic [1:0]          dec_used;
	logic [SW-1:0]       x_next;
	logic                is_decode;
	logic                byte_end;
	brcd_pkg::out_item_t res_d;

	assign s1_adv     = s1_valid_q && (!result_valid || result_ready);
	assign item_ready = !s1_valid_q || s1_adv;
	assign is_decode  = s1_adv && (item_s1.op == brcd_pkg::OP_DECODE);
	assign cur_lane   = {grp_q, pos_q};
	assign byte_end   = (pos_q == PW'(brcd_pkg::NODE_W - 1));

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_ready) begin
			s1_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// Counter banks: even nodes in one, odd nodes in the other, so both children
	// of a node come out of one read at the parent's index.
	brcd_ram #(.WIDTH(CW), .DEPTH(brcd_pkg::BANK_DEPTH)) u_even_bank (
		.clk   (clk),
		.we    (is_decode && !ctx_q[0]),
		.waddr (ctx_q[NW-1:1]),
		.wdata (cnt_new),
		.raddr (ctx_d[NW-1:1]),
		.rdata (even_rd)
	);

	brcd_ram #(.WIDTH(CW), .DEPTH(brcd_pkg::BANK_DEPTH)) u_odd_bank (
		.clk   (clk),
		.we    (is_decode && ctx_q[0]),
		.waddr (ctx_q[NW-1:1]),
		.wdata (cnt_new),
		.raddr (ctx_d[NW-1:1]),
		.rdata (odd_rd)
	);

	assign cnt_raw = ctx_q[0] ? odd_rd : even_rd;
	assign cnt_st  = cnt_valid_q[ctx_q] ? cnt_raw : '0;
	assign cnt_new = brcd_pkg::count_next(cnt_st, dec_bit);

	brcd_prob_rom u_prob_rom (
		.st (cnt_st),
		.p  (p)
	);

	brcd_rans_step u_step (
		.x           (lane_q[cur_lane]),
		.p           (p),
		.peek_first  (item_s1.peek_first),
		.peek_second (item_s1.peek_second),
		.bit_res     (dec_bit),
		.consumed    (dec_used),
		.x_next      (x_next)
	);

	// Next decode position
	always_comb begin
		ctx_d = ctx_q;
		pos_d = pos_q;
		grp_d = grp_q;
		if (s1_adv) begin
			case (item_s1.op)
				brcd_pkg::OP_LOAD: begin
					ctx_d = NW'(1);
					pos_d = '0;
					grp_d = 1'b0;
				end
				brcd_pkg::OP_DECODE: begin
					if (byte_end) begin
						ctx_d = NW'(1);
						pos_d = '0;
						grp_d = ~grp_q;
					end else begin
						ctx_d = {ctx_q[NW-2:0], dec_bit};
						pos_d = pos_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res_d           = '0;
		res_d.next_lane = {grp_d, pos_d};
		if (item_s1.op == brcd_pkg::OP_DECODE) begin
			res_d.bit_res   = dec_bit;
			res_d.consumed  = dec_used;
			res_d.byte_done = byte_end;
			res_d.out_byte  = byte_end ? {ctx_q[NW-2:0], dec_bit} : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q       <= NW'(1);
			pos_q       <= '0;
			grp_q       <= 1'b0;
			cnt_valid_q <= '0;
		end else begin
			ctx_q <= ctx_d;
			pos_q <= pos_d;
			grp_q <= grp_d;
			if (s1_adv && item_s1.op == brcd_pkg::OP_CLEAR) begin
				cnt_valid_q <= '0;
			end else if (is_decode) begin
				cnt_valid_q[ctx_q] <= 1'b1;
			end
		end
	end

	// Lane states
	always_ff @(posedge clk) begin
		if (s1_adv && item_s1.op == brcd_pkg::OP_LOAD) begin
			lane_q[item_s1.lane] <= item_s1.init_state;
		end else if (is_decode) begin
			lane_q[cur_lane] <= x_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (s1_adv) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result <= res_d;
		end
	end

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the binary rANS context decoder top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_PRINTS   = 20;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	brcd_pkg::in_item_t  item         = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	brcd_pkg::out_item_t result;

	int src_idle   = 0;
	int sink_stall = 0;
	int hold_gen   = 0;
	int hold_seen  = 0;
	int hold_left  = 0;
	int errors     = 0;

	// decoder state as the block should hold it
	logic [brcd_pkg::STATE_W-1:0] lane_st [brcd_pkg::LANES];
	logic [brcd_pkg::CNT_W-1:0]   cnt_st  [brcd_pkg::NODES];
	logic [brcd_pkg::NODE_W-1:0]  ctx_node;
	logic [brcd_pkg::POS_W-1:0]   bit_pos;
	logic                         grp_byte;

	brcd_pkg::out_item_t expected_decodes [$];

	binary_rans_context_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	function automatic brcd_pkg::out_item_t decode_step(input brcd_pkg::in_item_t it);
		brcd_pkg::out_item_t r;
		logic [3:0]  k;
		logic [7:0]  cnt;
		int unsigned n0;
		int unsigned n1;
		int unsigned p;
		int unsigned x;
		int unsigned s;
		int unsigned a;
		logic        b;
		r = '0;
		case (it.op)
			brcd_pkg::OP_LOAD: begin
				lane_st[it.lane] = it.init_state;
				ctx_node = 8'd1;
				bit_pos = '0;
				grp_byte = 1'b0;
			end
			brcd_pkg::OP_CLEAR: begin
				for (int i = 0; i < brcd_pkg::NODES; i++)
					cnt_st[i] = '0;
			end
			brcd_pkg::OP_DECODE: begin
				k = {grp_byte, bit_pos};
				cnt = cnt_st[ctx_node];
				n0 = cnt[3:0];
				n1 = cnt[7:4];
				p = ((2 * n0 + 1) << brcd_pkg::PROB_BITS) / (2 * (n0 + n1) + 2);
				x = lane_st[k];
				// refill: two bytes below 2^15, one byte below 2^23
				if (x < 32'h0000_8000) begin
					x = (x << 16) | (32'(it.peek_first) << 8) | 32'(it.peek_second);
					r.consumed = 2'd2;
				end else if (x < 32'h0080_0000) begin
					x = (x << 8) | 32'(it.peek_first);
					r.consumed = 2'd1;
				end
				s = x & 32'h0000_7FFF;
				a = p * (x >> brcd_pkg::PROB_BITS);
				b = (s >= p);
				x = b ? (x - p - a) : (a + s);
				lane_st[k] = x;
				if (b)
					n1 = n1 + 1;
				else
					n0 = n0 + 1;
				if (n0 > 15 || n1 > 15) begin
					n0 = (n0 + 1) / 2;
					n1 = (n1 + 1) / 2;
				end
				cnt_st[ctx_node] = 8'((n1 << 4) | n0);
				r.bit_res = b;
				if (bit_pos == 3'd7) begin
					r.byte_done = 1'b1;
					r.out_byte = {ctx_node[6:0], b};
					ctx_node = 8'd1;
					bit_pos = '0;
					grp_byte = ~grp_byte;
				end else begin
					ctx_node = {ctx_node[6:0], b};
					bit_pos = bit_pos + 3'd1;
				end
			end
			default: ;
		endcase
		r.next_lane = {grp_byte, bit_pos};
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		if (errors < MAX_PRINTS)
			$display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// predict on each accepted input, compare each accepted result
	always @(posedge clk or negedge arst_n) begin : result_check
		brcd_pkg::out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < brcd_pkg::NODES; i++)
				cnt_st[i] = '0;
			ctx_node = 8'd1;
			bit_pos = '0;
			grp_byte = 1'b0;
			expected_decodes.delete();
		end else begin
			if (item_valid && item_ready)
				expected_decodes.push_back(decode_step(item));
			if (result_valid && result_ready) begin
				if (expected_decodes.size() == 0) begin
					report_mismatch("unexpected result", result, 0);
				end else begin
					want = expected_decodes.pop_front();
					if (result.bit_res !== want.bit_res)
						report_mismatch("bit_res", result.bit_res, want.bit_res);
					if (result.consumed !== want.consumed)
						report_mismatch("consumed", result.consumed, want.consumed);
					if (result.byte_done !== want.byte_done)
						report_mismatch("byte_done", result.byte_done, want.byte_done);
					if (result.out_byte !== want.out_byte)
						report_mismatch("out_byte", result.out_byte, want.out_byte);
					if (result.next_lane !== want.next_lane)
						report_mismatch("next_lane", result.next_lane, want.next_lane);
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_seen != hold_gen) begin
			hold_seen <= hold_gen;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	function automatic brcd_pkg::in_item_t rand_item(input brcd_pkg::op_t op);
		brcd_pkg::in_item_t it;
		it.op = op;
		it.lane = 4'($urandom_range(brcd_pkg::LANES - 1));
		it.init_state = $urandom;
		it.peek_first = 8'($urandom);
		it.peek_second = 8'($urandom);
		return it;
	endfunction

	task automatic send_item(input brcd_pkg::in_item_t it);
		while ($urandom_range(99) < src_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	// let the checker see the last accepted transaction before watching the queue
	task automatic wait_idle;
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// load every lane, corner states on the first byte's lanes, decode one byte, then clear and no-op
	task automatic test_directed;
		logic [31:0]        corner [8];
		brcd_pkg::in_item_t it;
		corner = '{32'h0000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'h007F_FFFF,
			32'h0080_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h00FF_FFFF};
		for (int i = 0; i < brcd_pkg::LANES; i++) begin
			it = rand_item(brcd_pkg::OP_LOAD);
			it.lane = 4'(i);
			if (i < 8)
				it.init_state = corner[i];
			send_item(it);
		end
		for (int i = 0; i < 8; i++) begin
			it = rand_item(brcd_pkg::OP_DECODE);
			it.peek_first = i[0] ? 8'h00 : 8'hFF;
			it.peek_second = i[1] ? 8'hFF : 8'h00;
			send_item(it);
		end
		send_item(rand_item(brcd_pkg::OP_CLEAR));
		send_item(rand_item(brcd_pkg::OP_NONE));
		wait_idle();
	endtask

	// mostly decodes; clears kept rare so counters reach the overflow halving
	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n);
		int pick;
		src_idle <= src_pct;
		sink_stall <= sink_pct;
		repeat (n) begin
			pick = $urandom_range(199);
			if (pick < 186)
				send_item(rand_item(brcd_pkg::OP_DECODE));
			else if (pick < 194)
				send_item(rand_item(brcd_pkg::OP_LOAD));
			else if (pick < 196)
				send_item(rand_item(brcd_pkg::OP_CLEAR));
			else
				send_item(rand_item(brcd_pkg::OP_NONE));
		end
		wait_idle();
	endtask

	// hold the receiver off while the sender keeps offering decodes
	task automatic test_output_backpressure;
		src_idle <= 0;
		sink_stall <= 0;
		hold_gen <= hold_gen + 1;
		repeat (40)
			send_item(rand_item(brcd_pkg::OP_DECODE));
		wait_idle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(0, 0, 230);
		test_random_traffic(80, 0, 230);
		test_random_traffic(0, 80, 230);
		test_random_traffic(34, 34, 230);
		test_output_backpressure();
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
